[rtl/core/md5_pkg.sv]
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned BUF_WORDS = 16;
    localparam int unsigned ROUNDS = 64;

    // Controller to datapath
    typedef struct packed {
        logic       load_init;   // restore the initial chaining words, clear the count
        logic       put_byte;    // write wr_byte at wr_pos
        logic [5:0] wr_pos;
        logic [7:0] wr_byte;
        logic       count_byte;  // advance the bit count by one byte
        logic       put_len;     // write the bit count into words 14 and 15
        logic       round_start; // copy chaining words into the working set
        logic       round_en;    // run one round
        logic [5:0] round_idx;
        logic       round_fold;  // add the working set into the chaining words
    } md5_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [5:0] byte_pos;
    } md5_stat_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] round_word(input logic [5:0] i);
        logic [3:0] g;
        logic [3:0] l;
        l = i[3:0];
        case (i[5:4])
            2'd0:    g = l;
            2'd1:    g = 4'((l << 2) + l + 4'd1);
            2'd2:    g = 4'((l << 1) + l + 4'd5);
            default: g = 4'((l << 3) - l);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

[rtl/core/md5_ram.sv]
module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [WIDTH/8-1:0]       wr_be,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < WIDTH / 8; b++) begin
                if (wr_be[b]) begin
                    mem[wr_addr][b*8 +: 8] <= wr_data[b*8 +: 8];
                end
            end
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/md5_datapath.sv]
module md5_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  md5_pkg::md5_cmd_t cmd,
    output md5_pkg::md5_stat_t stat,
    output logic [127:0]      digest
);

    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [63:0] count_reg;

    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  wr_be;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;

    // Read address runs one round ahead: the controller issues the index early
    assign rd_addr = md5_pkg::round_word(cmd.round_idx);

    always_comb begin
        wr_en   = cmd.put_byte || cmd.put_len;
        wr_addr = cmd.wr_pos[5:2];
        wr_data = {4{cmd.wr_byte}};
        wr_be   = 4'b0001 << cmd.wr_pos[1:0];
        if (cmd.put_len) begin
            wr_addr = cmd.wr_pos[2] ? 4'd15 : 4'd14;
            wr_data = cmd.wr_pos[2] ? count_reg[63:32] : count_reg[31:0];
            wr_be   = 4'b1111;
        end
    end

    md5_ram #(.WIDTH(32), .DEPTH(md5_pkg::BUF_WORDS)) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .wr_be   (wr_be),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [5:0]  ridx_reg;
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  s;
    logic [63:0] rot;

    always_comb begin
        case (ridx_reg[5:4])
            2'd0:    f = wd_reg ^ (wb_reg & (wc_reg ^ wd_reg));
            2'd1:    f = wc_reg ^ (wd_reg & (wb_reg ^ wc_reg));
            2'd2:    f = wb_reg ^ wc_reg ^ wd_reg;
            default: f = wc_reg ^ (wb_reg | ~wd_reg);
        endcase
        sum = wa_reg + f + md5_pkg::round_const(ridx_reg) + rd_data;
        s   = md5_pkg::round_shift(ridx_reg);
        rot = {sum, sum} << s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ca_reg    <= md5_pkg::INIT_A;
            cb_reg    <= md5_pkg::INIT_B;
            cc_reg    <= md5_pkg::INIT_C;
            cd_reg    <= md5_pkg::INIT_D;
            count_reg <= '0;
        end else begin
            if (cmd.count_byte) count_reg <= count_reg + 64'd8;
            if (cmd.round_fold) begin
                ca_reg <= ca_reg + wa_reg;
                cb_reg <= cb_reg + wb_reg;
                cc_reg <= cc_reg + wc_reg;
                cd_reg <= cd_reg + wd_reg;
            end
            if (cmd.load_init) begin
                ca_reg    <= md5_pkg::INIT_A;
                cb_reg    <= md5_pkg::INIT_B;
                cc_reg    <= md5_pkg::INIT_C;
                cd_reg    <= md5_pkg::INIT_D;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg <= cmd.round_idx;
        if (cmd.round_start) begin
            wa_reg <= ca_reg;
            wb_reg <= cb_reg;
            wc_reg <= cc_reg;
            wd_reg <= cd_reg;
        end else if (cmd.round_en) begin
            wa_reg <= wd_reg;
            wb_reg <= wb_reg + rot[63:32];
            wc_reg <= wb_reg;
            wd_reg <= wc_reg;
        end
    end

    assign stat.byte_pos = count_reg[8:3];
    assign digest = {md5_pkg::swap32(ca_reg), md5_pkg::swap32(cb_reg),
                     md5_pkg::swap32(cc_reg), md5_pkg::swap32(cd_reg)};

endmodule

[rtl/core/md5_ctrl.sv]
module md5_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_byte_valid,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_part,
    output md5_pkg::md5_cmd_t  cmd,
    input  md5_pkg::md5_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LEN   = 7'b0000100,
        S_START = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_FOLD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;     // padding write position
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;     // message end under way
    logic        part_reg, part_next;
    logic        lenblk_reg, lenblk_next; // current block carries the length

    logic accept;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_part  = part_reg;

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        rnd_next    = rnd_reg;
        fin_next    = fin_reg;
        part_next   = part_reg;
        lenblk_next = lenblk_reg;
        cmd         = '0;
        cmd.round_idx = rnd_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_byte_valid) begin
                        cmd.put_byte   = 1'b1;
                        cmd.wr_pos     = stat.byte_pos;
                        cmd.wr_byte    = in_byte;
                        cmd.count_byte = 1'b1;
                    end
                    fin_next = in_last;
                    if (in_byte_valid && stat.byte_pos == 6'd63) begin
                        lenblk_next = 1'b0;
                        state_next  = S_START;
                    end else if (in_last) begin
                        pos_next    = in_byte_valid ? 6'(stat.byte_pos + 6'd1) : stat.byte_pos;
                        lenblk_next = 1'b0;
                        state_next  = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // Write 0x80 at the end position, then zeros to the block end
                cmd.put_byte = 1'b1;
                cmd.wr_pos   = pos_reg;
                cmd.wr_byte  = (pos_reg == stat.byte_pos) ? md5_pkg::PAD_BYTE : 8'h00;
                pos_next     = 6'(pos_reg + 6'd1);
                if (pos_reg == 6'd63) begin
                    if (stat.byte_pos >= 6'd56 && !lenblk_reg) begin
                        state_next = S_START;
                    end else begin
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN: begin
                cmd.put_len = 1'b1;
                cmd.wr_pos  = pos_reg;
                pos_next    = 6'(pos_reg + 6'd4);
                if (pos_reg[2]) begin
                    lenblk_next = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                cmd.round_start = 1'b1;
                cmd.round_idx   = 6'd0;
                rnd_next        = 6'd1;
                state_next      = S_ROUND;
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                rnd_next     = 6'(rnd_reg + 6'd1);
                if (rnd_reg == 6'd0) state_next = S_FOLD;
            end
            S_FOLD: begin
                cmd.round_fold = 1'b1;
                if (!fin_reg) begin
                    state_next = S_IDLE;
                end else if (!lenblk_reg) begin
                    // Overflowed length block: zero the words ahead of the length,
                    // the next block carries it
                    pos_next    = 6'd0;
                    lenblk_next = 1'b1;
                    state_next  = S_PAD;
                end else begin
                    part_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) begin
                    part_next = 1'b1;
                    if (part_reg) begin
                        cmd.load_init = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            part_reg   <= 1'b0;
            lenblk_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            part_reg   <= part_next;
            lenblk_reg <= lenblk_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        rnd_reg <= rnd_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !accept) else $error("request taken while busy");
    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND && rnd_reg == 6'd0) |=> (state_reg == S_FOLD))
        else $error("round sequence did not end in fold");
    a_out_after_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == S_OUT) |-> $past(state_reg == S_FOLD) && fin_reg && lenblk_reg)
        else $error("digest shown without a length block");

endmodule

[rtl/core/md5_stream_hash.sv]
// MD5 digest over a byte stream.
// Input channel s_axis: one request per message byte. s_axis_tdata[7:0] is the
// byte; s_axis_tuser[0] marks the byte valid, s_axis_tlast ends the message
// (it may carry no byte, so an empty message is possible).
// Output channel m_axis: two 64-bit results per message, digest byte 0 in the
// top byte of the first. m_axis_tuser[0] is the part index, m_axis_tlast the
// final result.
// Throughput: one byte is taken per cycle while idle; the 64th byte of a block
// adds the compression (one MD5 round per cycle through the single round unit,
// plus start and fold), during which no further byte is taken.
// A last request pads each block to its end (spilling into a second block
// when the length does not fit), writes the length and runs
// one or two compressions before the digest shows.
// Reset restores the initial chaining words and clears the bit count. While
// the receiver stalls the digest holds and no input request is taken; after
// the second result the block restarts for the next message.
module md5_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [0:0]  m_axis_tuser,   // [0] part_index
    output logic        m_axis_tlast    // is_final
);

    md5_pkg::md5_cmd_t  cmd;
    md5_pkg::md5_stat_t stat;
    logic [127:0]       digest;
    logic               part;

    md5_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_byte       (s_axis_tdata),
        .in_byte_valid (s_axis_tuser[0]),
        .in_last       (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_part      (part),
        .cmd           (cmd),
        .stat          (stat)
    );

    md5_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .digest  (digest)
    );

    assign m_axis_tdata    = part ? digest[63:0] : digest[127:64];
    assign m_axis_tuser[0] = part;
    assign m_axis_tlast    = part;

endmodule
